### rtl/access_hotspot_tracker_macros.svh
// Assertion macros used by the hotspot tracker RTL.
`ifndef ACCESS_HOTSPOT_TRACKER_MACROS_SVH
`define ACCESS_HOTSPOT_TRACKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ahs assertion failed");

// Next-cycle implication, checked out of reset.
`define AHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ahs assertion failed");

// Invariant, checked out of reset.
`define AHS_ASSERT_ALW(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ahs assertion failed");

`endif

### rtl/ahs_pkg.sv
// Package with constants and types of the hotspot tracker.
package ahs_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OUT_SLOT_W = 6;
  localparam int POS_W      = 16;
  localparam int CNT_W      = 16;
  localparam int STAMP_W    = 32;
  localparam int RADIUS_W   = 8;
  localparam int THRESH_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(2);
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(5);
  localparam logic [CNT_W-1:0]    CNT_NEW    = CNT_W'(1);
  localparam logic [CNT_W-1:0]    CNT_MAX    = '1;

  // Search record handed from cell to cell.
  typedef struct packed {
    logic               vld;
    logic [POS_W-1:0]   pos;
    logic               dir;
    logic               found;
    logic [SLOT_W-1:0]  hit_slot;
    logic [CNT_W-1:0]   hit_count;
    logic               hit_flag;
    logic               free_found;
    logic [SLOT_W-1:0]  free_slot;
    logic [STAMP_W-1:0] old_stamp;
    logic [SLOT_W-1:0]  old_slot;
  } ahs_rec_t;

  // Write-back command broadcast to all cells.
  typedef struct packed {
    logic               en;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   pos;
    logic               dir;
    logic [STAMP_W-1:0] stamp;
  } ahs_wr_t;

  // One result item.
  typedef struct packed {
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  replaced;
    logic [CNT_W-1:0]      count;
    logic                  pinned;
  } ahs_res_t;

endpackage

### rtl/ahs_if.sv
// Channel interfaces of the hotspot tracker: access, result and configuration.
interface ahs_in_if import ahs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             direction_changed;
  modport source (output valid, position, direction_changed, input ready);
  modport sink (input valid, position, direction_changed, output ready);
endinterface

interface ahs_out_if import ahs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [OUT_SLOT_W-1:0] slot;
  logic                  replaced;
  logic [CNT_W-1:0]      access_count;
  logic                  pinned;
  modport source (output valid, hit, slot, replaced, access_count, pinned, input ready);
  modport sink (input valid, hit, slot, replaced, access_count, pinned, output ready);
endinterface

interface ahs_cfg_if import ahs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/ahs_cell.sv
// One table slot: holds an entry and advances the search record by one slot.
module ahs_cell import ahs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SLOT_W-1:0]   idx,
  input  logic [RADIUS_W-1:0] radius,
  input  ahs_rec_t            rec_i,
  output ahs_rec_t            rec_o,
  input  ahs_wr_t             wr
);

  logic               valid_r;
  logic [POS_W-1:0]   pos_r;
  logic [CNT_W-1:0]   count_r;
  logic               flag_r;
  logic [STAMP_W-1:0] stamp_r;

  ahs_rec_t         rec_r, rec_nxt;
  logic [POS_W-1:0] pos_gap;
  logic             near;
  logic             wr_me;

  assign pos_gap = (pos_r > rec_i.pos) ? (pos_r - rec_i.pos) : (rec_i.pos - pos_r);
  assign near    = valid_r && (pos_gap <= POS_W'(radius));
  assign wr_me   = wr.en && (wr.slot == idx);

  always_comb begin
    rec_nxt = rec_i;
    if (!rec_i.found && near) begin
      rec_nxt.found     = 1'b1;
      rec_nxt.hit_slot  = idx;
      rec_nxt.hit_count = count_r;
      rec_nxt.hit_flag  = flag_r;
    end
    if (!rec_i.free_found && !valid_r) begin
      rec_nxt.free_found = 1'b1;
      rec_nxt.free_slot  = idx;
    end
    // Strictly older wins, so the lowest slot keeps ties.
    if (valid_r && (stamp_r < rec_i.old_stamp)) begin
      rec_nxt.old_stamp = stamp_r;
      rec_nxt.old_slot  = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.vld <= 1'b0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_o = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_me) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_me) begin
      stamp_r <= wr.stamp;
      if (wr.hit) begin
        if (count_r != CNT_MAX) begin
          count_r <= count_r + CNT_W'(1);
        end
      end else begin
        pos_r   <= wr.pos;
        count_r <= CNT_NEW;
        flag_r  <= wr.dir;
      end
    end
  end

endmodule

### rtl/access_hotspot_tracker.sv
// Top level of the access hotspot tracker: cell chain, write-back and channels.
// Usage:
//   in_ch   accesses (position, direction_changed); transfer on valid & ready.
//   out_ch  one result per access (hit, slot, replaced, access_count, pinned).
//   cfg_ch  register writes: index 0 match_radius, 1 pin_threshold; always ready.
//   An accepted access enters a chain of SLOTS cells and moves one cell per
//   cycle; each cell compares it against its own entry. At the chain end the
//   decision is broadcast back to the cells as a write-back and the result is
//   captured in a pending stage and then in the output register. Only one
//   access is in flight at a time: in_ch ready stays low from the input
//   transfer until the result has left the pending stage for the output
//   register.
//   Reset: table empty, access clock zero, match_radius 2, pin_threshold 5.
//   Stall: a finished result waits in the output register while the next
//   access is already accepted and scanned; a second result then waits in a
//   pending stage, and in_ch ready stays low until that stage drains.
`include "access_hotspot_tracker_macros.svh"

module access_hotspot_tracker import ahs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ahs_in_if.sink     in_ch,
  ahs_out_if.source  out_ch,
  ahs_cfg_if.sink    cfg_ch
);

  logic [RADIUS_W-1:0] radius_r;
  logic [THRESH_W-1:0] thresh_r;
  logic [STAMP_W-1:0]  clock_r;
  logic                busy_r;
  logic                pend_r;
  ahs_res_t            pend_res_r;
  logic                out_vld_r;
  ahs_res_t            out_res_r;

  ahs_rec_t            chain [SLOTS+1];
  logic [SLOTS:0]      chain_vld;
  ahs_rec_t            tail;
  ahs_wr_t             wr;
  ahs_res_t            res;
  logic                in_xfer;
  logic                out_load;
  logic [CNT_W-1:0]    res_count;
  logic                res_flag;

  // Configuration registers; any index beyond the list is dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MATCH_RADIUS:  radius_r <= cfg_ch.data[RADIUS_W-1:0];
        CFG_PIN_THRESHOLD: thresh_r <= cfg_ch.data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Launch a fresh search record into the first cell on an input transfer.
  assign in_ch.ready = !busy_r && !pend_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    chain[0]            = '0;
    chain[0].vld        = in_xfer;
    chain[0].pos        = in_ch.position;
    chain[0].dir        = in_ch.direction_changed;
    chain[0].old_stamp  = '1;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ahs_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .idx    (SLOT_W'(g)),
      .radius (radius_r),
      .rec_i  (chain[g]),
      .rec_o  (chain[g+1]),
      .wr     (wr)
    );
  end

  for (genvar g = 0; g <= SLOTS; g++) begin : g_vld
    assign chain_vld[g] = chain[g].vld;
  end

  assign tail = chain[SLOTS];

  // Decide the touched slot: first match, else lowest free, else oldest.
  always_comb begin
    wr.en    = tail.vld;
    wr.hit   = tail.found;
    wr.pos   = tail.pos;
    wr.dir   = tail.dir;
    wr.stamp = clock_r;
    if (tail.found) begin
      wr.slot = tail.hit_slot;
    end else if (tail.free_found) begin
      wr.slot = tail.free_slot;
    end else begin
      wr.slot = tail.old_slot;
    end
  end

  // Result: count and flag of the entry as it stands after the write-back.
  always_comb begin
    if (tail.found) begin
      res_count = (tail.hit_count == CNT_MAX) ? CNT_MAX : tail.hit_count + CNT_W'(1);
      res_flag  = tail.hit_flag;
    end else begin
      res_count = CNT_NEW;
      res_flag  = tail.dir;
    end
    res.hit      = tail.found;
    res.slot     = OUT_SLOT_W'(wr.slot);
    res.replaced = !tail.found && !tail.free_found;
    res.count    = res_count;
    res.pinned   = res_flag || (res_count > thresh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      clock_r <= '0;
    end else begin
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (tail.vld) begin
        busy_r <= 1'b0;
      end
      // Advance the access clock once per access, wrapping.
      if (tail.vld) begin
        clock_r <= clock_r + STAMP_W'(1);
      end
    end
  end

  // Pending stage, then output register.
  assign out_load = pend_r && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (tail.vld) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      pend_res_r <= res;
    end
    if (out_load) begin
      out_res_r <= pend_res_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.hit          = out_res_r.hit;
  assign out_ch.slot         = out_res_r.slot;
  assign out_ch.replaced     = out_res_r.replaced;
  assign out_ch.access_count = out_res_r.count;
  assign out_ch.pinned       = out_res_r.pinned;

  // At most one search record travels down the chain.
  `AHS_ASSERT_ALW(a_one_record, clk, rst_n, $onehot0(chain_vld))
  // A record reaching the chain end belongs to an access still in flight.
  `AHS_ASSERT_IMP(a_tail_busy, clk, rst_n, tail.vld, busy_r && !pend_r)
  // Scanning and a held pending result never overlap.
  `AHS_ASSERT_ALW(a_busy_pend, clk, rst_n, !(busy_r && pend_r))
  // Each write-back advances the access clock by exactly one.
  `AHS_ASSERT_NXT(a_clock_step, clk, rst_n, tail.vld, clock_r == $past(clock_r) + STAMP_W'(1))

endmodule
